### rtl/jaf_pkg.sv
package jaf_pkg;

    localparam int unsigned DEFAULT_MAX_DEPTH = 255;
    localparam int unsigned COUNT_W           = 24;
    localparam int unsigned STATUS_W          = 3;
    localparam int unsigned PHASE_W           = 3;

    // Framing phases
    localparam logic [PHASE_W-1:0] PH_OPEN   = 3'd0;  // expect '['
    localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd1;  // after '[': '{' or ']'
    localparam logic [PHASE_W-1:0] PH_INOBJ  = 3'd2;  // inside an object
    localparam logic [PHASE_W-1:0] PH_SEP    = 3'd3;  // after object: ',' or ']'
    localparam logic [PHASE_W-1:0] PH_NEXT   = 3'd4;  // after ',': '{'
    localparam logic [PHASE_W-1:0] PH_CLOSED = 3'd5;  // after ']': whitespace only
    localparam logic [PHASE_W-1:0] PH_FAILED = 3'd6;  // sticky error

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BRACKET = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BRACE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EARLY_END  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRAILING   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_SEP    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TOO_DEEP   = 3'd6;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                in_object;
        logic                object_end;
        logic                stream_done;
        logic [COUNT_W-1:0]  objects_seen;
        logic [STATUS_W-1:0] status;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
    endfunction

endpackage

### rtl/jaf_core.sv
module jaf_core #(
    parameter int unsigned MAX_DEPTH = jaf_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_stream,
    output jaf_pkg::result_t result
);

    localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

    logic [jaf_pkg::PHASE_W-1:0]  phase_reg,  phase_next;
    logic [DEPTH_W-1:0]           depth_reg,  depth_next;
    logic [jaf_pkg::COUNT_W-1:0]  total_reg,  total_next;
    logic [jaf_pkg::STATUS_W-1:0] error_reg,  error_next;
    logic                         inobj, oend, done, space;

    always_comb
    begin
        phase_next = phase_reg;
        depth_next = depth_reg;
        total_next = total_reg;
        error_next = error_reg;
        inobj      = 1'b0;
        oend       = 1'b0;
        done       = 1'b0;
        space      = jaf_pkg::is_space(in_byte);

        if (end_of_stream)
        begin
            unique case (phase_reg)
                jaf_pkg::PH_OPEN:
                    error_next = jaf_pkg::ST_NO_BRACKET;
                jaf_pkg::PH_FIRST, jaf_pkg::PH_NEXT:
                    error_next = jaf_pkg::ST_NO_BRACE;
                jaf_pkg::PH_INOBJ, jaf_pkg::PH_SEP:
                    error_next = jaf_pkg::ST_EARLY_END;
                jaf_pkg::PH_CLOSED:
                    done = 1'b1;
                default:
                    error_next = error_reg;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                jaf_pkg::PH_OPEN:
                begin
                    if (in_byte == jaf_pkg::CH_LBRACKET)
                        phase_next = jaf_pkg::PH_FIRST;
                    else if (!space)
                    begin
                        phase_next = jaf_pkg::PH_FAILED;
                        error_next = jaf_pkg::ST_NO_BRACKET;
                    end
                end
                jaf_pkg::PH_FIRST, jaf_pkg::PH_NEXT:
                begin
                    if (in_byte == jaf_pkg::CH_LBRACE)
                    begin
                        phase_next = jaf_pkg::PH_INOBJ;
                        depth_next = DEPTH_W'(1);
                        inobj      = 1'b1;
                    end
                    else if (phase_reg == jaf_pkg::PH_FIRST &&
                             in_byte == jaf_pkg::CH_RBRACKET)
                        phase_next = jaf_pkg::PH_CLOSED;
                    else if (!space)
                    begin
                        phase_next = jaf_pkg::PH_FAILED;
                        error_next = jaf_pkg::ST_NO_BRACE;
                    end
                end
                jaf_pkg::PH_INOBJ:
                begin
                    inobj = 1'b1;
                    if (in_byte == jaf_pkg::CH_LBRACE)
                    begin
                        if (depth_reg >= DEPTH_LIMIT)
                        begin
                            // nesting limit hit: this brace is not part of the object
                            inobj      = 1'b0;
                            phase_next = jaf_pkg::PH_FAILED;
                            error_next = jaf_pkg::ST_TOO_DEEP;
                        end
                        else
                            depth_next = depth_reg + 1'b1;
                    end
                    else if (in_byte == jaf_pkg::CH_RBRACE)
                    begin
                        depth_next = depth_reg - 1'b1;
                        if (depth_reg == DEPTH_W'(1))
                        begin
                            oend       = 1'b1;
                            phase_next = jaf_pkg::PH_SEP;
                            if (total_reg != jaf_pkg::COUNT_MAX)
                                total_next = total_reg + 1'b1;
                        end
                    end
                end
                jaf_pkg::PH_SEP:
                begin
                    if (in_byte == jaf_pkg::CH_COMMA)
                        phase_next = jaf_pkg::PH_NEXT;
                    else if (in_byte == jaf_pkg::CH_RBRACKET)
                        phase_next = jaf_pkg::PH_CLOSED;
                    else if (!space)
                    begin
                        phase_next = jaf_pkg::PH_FAILED;
                        error_next = jaf_pkg::ST_BAD_SEP;
                    end
                end
                jaf_pkg::PH_CLOSED:
                begin
                    if (!space)
                    begin
                        phase_next = jaf_pkg::PH_FAILED;
                        error_next = jaf_pkg::ST_TRAILING;
                    end
                end
                default:
                    phase_next = phase_reg;
            endcase
        end

        result.out_byte     = end_of_stream ? 8'h00 : in_byte;
        result.in_object    = inobj;
        result.object_end   = oend;
        result.stream_done  = done;
        result.objects_seen = total_next;
        result.status       = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jaf_pkg::PH_OPEN;
            depth_reg <= '0;
            total_reg <= '0;
            error_reg <= jaf_pkg::ST_OK;
        end
        else if (accept)
        begin
            if (end_of_stream)
            begin
                // report above, then rearm for the next stream
                phase_reg <= jaf_pkg::PH_OPEN;
                depth_reg <= '0;
                total_reg <= '0;
                error_reg <= jaf_pkg::ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                depth_reg <= depth_next;
                total_reg <= total_next;
                error_reg <= error_next;
            end
        end
    end

    a_error_only_when_failed: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == jaf_pkg::PH_FAILED) == (error_reg != jaf_pkg::ST_OK))
        else $error("error code and failed phase disagree");

    a_depth_inside_object: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == jaf_pkg::PH_INOBJ) |-> (depth_reg != '0))
        else $error("zero brace depth inside an object");

    a_rearm_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_stream) |=>
            (phase_reg == jaf_pkg::PH_OPEN && total_reg == '0))
        else $error("block not rearmed after end marker");

endmodule

### rtl/json_object_array_framer.sv
// JSON array-of-objects framer.
// Input stream: one raw byte per item in s_tdata; s_tlast marks the end of a
// stream (its byte is ignored). Output stream: one result item per input item,
// with the byte passed through, object flags in m_tuser and the running object
// count and sticky status in m_tdata.
// The result is loaded into the output register when its input item is accepted.
// Throughput: one item per cycle unless the receiver stalls; every byte only
// updates the small phase, depth, count and status registers in a single pass.
// When the receiver stalls, the output register holds its item and s_tready
// drops only while that item waits; a new item is taken in the same cycle the
// held one leaves.
// Reset puts the framer in its expect-'[' phase with zero depth, count and
// status, and empties the output register. The end-of-stream item reports
// the outcome of the stream and then rearms the framer the same way.
module json_object_array_framer #(
    parameter int unsigned MAX_DEPTH = jaf_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [31:8] objects_seen, [34:32] status
    output logic [2:0]  m_tuser    // [0] in_object, [1] object_end, [2] stream_done
);

    jaf_pkg::result_t result, result_reg;
    logic             valid_reg;
    logic             accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    jaf_core #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (s_tdata),
        .end_of_stream(s_tlast),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, result_reg.status, result_reg.objects_seen, result_reg.out_byte};
    assign m_tuser  = {result_reg.stream_done, result_reg.object_end, result_reg.in_object};

    a_end_inside_object: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!result_reg.object_end || result_reg.in_object))
        else $error("object end flagged outside an object");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result_reg.stream_done) |-> (result_reg.status == jaf_pkg::ST_OK))
        else $error("stream done with error status");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !accept)
        else $error("item accepted over a held result");

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH_LIMIT = jaf_pkg::DEFAULT_MAX_DEPTH;
    localparam int unsigned TOTAL_ITEMS = 850;

    // Tracks the framer state and queues the expected result of each accepted item.
    class framer_scoreboard;
        logic [jaf_pkg::PHASE_W-1:0]  stage;
        int unsigned                  brace_level;
        logic [jaf_pkg::COUNT_W-1:0]  finished;
        logic [jaf_pkg::STATUS_W-1:0] fault;
        jaf_pkg::result_t             pending[$];
        int                           errors;
        int                           results_seen;

        function new();
            rearm();
            errors       = 0;
            results_seen = 0;
        endfunction

        function void rearm();
            stage       = jaf_pkg::PH_OPEN;
            brace_level = 0;
            finished    = '0;
            fault       = jaf_pkg::ST_OK;
        endfunction

        function void latch_fault(logic [jaf_pkg::STATUS_W-1:0] code);
            fault = code;
            stage = jaf_pkg::PH_FAILED;
        endfunction

        function bit blank(logic [7:0] c);
            return (c == jaf_pkg::CH_TAB) || (c == jaf_pkg::CH_LF) ||
                   (c == jaf_pkg::CH_CR) || (c == jaf_pkg::CH_SPACE);
        endfunction

        function void note_input(logic [7:0] c, logic eos);
            jaf_pkg::result_t r;
            r = '0;
            r.out_byte = eos ? 8'h00 : c;
            if (eos)
            begin
                unique case (stage)
                    jaf_pkg::PH_OPEN:
                        latch_fault(jaf_pkg::ST_NO_BRACKET);
                    jaf_pkg::PH_FIRST, jaf_pkg::PH_NEXT:
                        latch_fault(jaf_pkg::ST_NO_BRACE);
                    jaf_pkg::PH_INOBJ, jaf_pkg::PH_SEP:
                        latch_fault(jaf_pkg::ST_EARLY_END);
                    jaf_pkg::PH_CLOSED:
                        r.stream_done = 1'b1;
                    default: ;
                endcase
            end
            else
            begin
                unique case (stage)
                    jaf_pkg::PH_OPEN:
                    begin
                        if (c == jaf_pkg::CH_LBRACKET)
                            stage = jaf_pkg::PH_FIRST;
                        else if (!blank(c))
                            latch_fault(jaf_pkg::ST_NO_BRACKET);
                    end
                    jaf_pkg::PH_FIRST, jaf_pkg::PH_NEXT:
                    begin
                        if (c == jaf_pkg::CH_LBRACE)
                        begin
                            stage       = jaf_pkg::PH_INOBJ;
                            brace_level = 1;
                            r.in_object = 1'b1;
                        end
                        else if (stage == jaf_pkg::PH_FIRST && c == jaf_pkg::CH_RBRACKET)
                            stage = jaf_pkg::PH_CLOSED;
                        else if (!blank(c))
                            latch_fault(jaf_pkg::ST_NO_BRACE);
                    end
                    jaf_pkg::PH_INOBJ:
                    begin
                        // the overflowing brace is dropped, not part of the object
                        if (c == jaf_pkg::CH_LBRACE && brace_level >= DEPTH_LIMIT)
                            latch_fault(jaf_pkg::ST_TOO_DEEP);
                        else
                        begin
                            if (c == jaf_pkg::CH_LBRACE)
                                brace_level++;
                            else if (c == jaf_pkg::CH_RBRACE)
                            begin
                                brace_level--;
                                if (brace_level == 0)
                                begin
                                    r.object_end = 1'b1;
                                    if (finished != jaf_pkg::COUNT_MAX)
                                        finished++;
                                    stage = jaf_pkg::PH_SEP;
                                end
                            end
                            r.in_object = 1'b1;
                        end
                    end
                    jaf_pkg::PH_SEP:
                    begin
                        if (c == jaf_pkg::CH_COMMA)
                            stage = jaf_pkg::PH_NEXT;
                        else if (c == jaf_pkg::CH_RBRACKET)
                            stage = jaf_pkg::PH_CLOSED;
                        else if (!blank(c))
                            latch_fault(jaf_pkg::ST_BAD_SEP);
                    end
                    jaf_pkg::PH_CLOSED:
                    begin
                        if (!blank(c))
                            latch_fault(jaf_pkg::ST_TRAILING);
                    end
                    default: ;
                endcase
            end
            r.objects_seen = finished;
            r.status       = fault;
            pending.push_back(r);
            if (eos)
                rearm();
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            errors++;
            if (errors <= 40)
                $display("mismatch on result %0d: %s = 0x%0h, expected 0x%0h",
                         results_seen, what, got, want);
        endtask

        task check_result(logic [39:0] d, logic [2:0] u);
            jaf_pkg::result_t e;
            results_seen++;
            if (pending.size() == 0)
            begin
                report("unexpected item, m_tdata", d, 0);
                return;
            end
            e = pending.pop_front();
            if (d[7:0] !== e.out_byte)
                report("out_byte", d[7:0], e.out_byte);
            if (d[31:8] !== e.objects_seen)
                report("objects_seen", d[31:8], e.objects_seen);
            if (d[34:32] !== e.status)
                report("status", d[34:32], e.status);
            if (d[39:35] !== 5'b0)
                report("m_tdata pad bits", d[39:35], 0);
            if (u[0] !== e.in_object)
                report("in_object", u[0], e.in_object);
            if (u[1] !== e.object_end)
                report("object_end", u[1], e.object_end);
            if (u[2] !== e.stream_done)
                report("stream_done", u[2], e.stream_done);
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    framer_scoreboard sb;
    logic [7:0]       stream_q[$];
    int               burst_left = 0;
    int               items_sent = 0;
    int               rx_mode    = 0;
    int               rx_left    = 0;

    json_object_array_framer #(
        .MAX_DEPTH (DEPTH_LIMIT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // Receiver: switches between always ready, mostly ready, toggling and long stalls.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        unique case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ~m_tready;
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata, s_tlast);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        items_sent++;
        s_tdata  <= b;
        s_tlast  <= eos;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // the byte under an end marker is junk on purpose
    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_stream();
        foreach (stream_q[i])
            send_byte(stream_q[i], 1'b0);
        send_end();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_blank();
        unique case ($urandom_range(0, 3))
            0:       return jaf_pkg::CH_TAB;
            1:       return jaf_pkg::CH_LF;
            2:       return jaf_pkg::CH_CR;
            default: return jaf_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic void add_blanks();
        repeat ($urandom_range(0, 2))
            stream_q.push_back(pick_blank());
    endfunction

    // anything but a brace: half JSON-like text, half raw bytes
    function automatic logic [7:0] filler();
        string      alpha;
        logic [7:0] b;
        alpha = "\"ab01:,[] -.e";
        if ($urandom_range(0, 1))
            return alpha[$urandom_range(0, alpha.len() - 1)];
        do
            b = 8'($urandom_range(0, 255));
        while (b == jaf_pkg::CH_LBRACE || b == jaf_pkg::CH_RBRACE);
        return b;
    endfunction

    function automatic void add_object();
        int lvl;
        int steps;
        stream_q.push_back(jaf_pkg::CH_LBRACE);
        lvl   = 1;
        steps = 0;
        while (lvl > 0)
        begin
            steps++;
            if (steps > 24)
            begin
                stream_q.push_back(jaf_pkg::CH_RBRACE);
                lvl--;
            end
            else
            begin
                unique case ($urandom_range(0, 9))
                    0:
                    begin
                        if (lvl < 4)
                        begin
                            stream_q.push_back(jaf_pkg::CH_LBRACE);
                            lvl++;
                        end
                    end
                    1:
                    begin
                        stream_q.push_back(jaf_pkg::CH_RBRACE);
                        lvl--;
                    end
                    default: stream_q.push_back(filler());
                endcase
            end
        end
    endfunction

    // one object nested to the given depth; optionally one brace past the limit
    task automatic deep_nest(input int levels, input bit overflow);
        stream_q.delete();
        stream_q.push_back(jaf_pkg::CH_LBRACKET);
        repeat (levels)
        begin
            stream_q.push_back(jaf_pkg::CH_LBRACE);
            if ($urandom_range(0, 7) == 0)
                stream_q.push_back(filler());
        end
        if (overflow)
            stream_q.push_back(jaf_pkg::CH_LBRACE);
        else
        begin
            repeat (levels)
                stream_q.push_back(jaf_pkg::CH_RBRACE);
            stream_q.push_back(jaf_pkg::CH_RBRACKET);
        end
        send_stream();
    endtask

    initial
    begin
        int kind;
        int nobj;
        int pos;
        int cut;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_end();                                 // end before any bracket
        send_text("[]");
        send_end();
        send_text(" \t\r\n[ {\"a\":{}} ,\n{} ]\t");
        send_end();
        send_text("x[");                            // wrong first byte
        send_end();
        send_text("[");                             // end where an object must start
        send_end();
        send_text("[x");
        send_end();
        send_text("[{}x");                          // bad separator
        send_end();
        send_text("[{}");                           // early end after an object
        send_end();
        send_text("[{},]");                         // missing object after comma
        send_end();
        send_text("[] x");                          // trailing data after empty array
        send_end();
        send_text("[{");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("}]");
        send_end();
        drain();

        deep_nest(DEPTH_LIMIT, 1'b1);
        deep_nest(DEPTH_LIMIT, 1'b0);

        while (items_sent < TOTAL_ITEMS)
        begin
            stream_q.delete();
            kind = $urandom_range(0, 9);
            if (kind == 9)
            begin
                // noise: everything after the first bad byte is ignored
                repeat ($urandom_range(1, 8))
                    stream_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                add_blanks();
                stream_q.push_back(jaf_pkg::CH_LBRACKET);
                add_blanks();
                nobj = $urandom_range(0, 5);
                for (int k = 0; k < nobj; k++)
                begin
                    if (k > 0)
                    begin
                        stream_q.push_back(jaf_pkg::CH_COMMA);
                        add_blanks();
                    end
                    add_object();
                    add_blanks();
                end
                stream_q.push_back(jaf_pkg::CH_RBRACKET);
                add_blanks();
                if (kind == 7)
                begin
                    pos = $urandom_range(0, stream_q.size() - 1);
                    stream_q[pos] = 8'($urandom_range(0, 255));
                    cut = pos + 1 + $urandom_range(0, 4);
                    while (stream_q.size() > cut)
                        void'(stream_q.pop_back());
                end
                else if (kind == 8)
                begin
                    cut = $urandom_range(0, stream_q.size() - 1);
                    while (stream_q.size() > cut)
                        void'(stream_q.pop_back());
                end
            end
            send_stream();
            if ($urandom_range(0, 29) == 0)
                drain();
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
rtl/jaf_pkg.sv
rtl/jaf_core.sv
rtl/json_object_array_framer.sv
dv/testbench.sv
